/* rtl/pesw_pkg.sv */
// ---------------------------------------------------------------------------
// pesw_pkg: shared types and microcode for the pes header writer
// byte source selects, branch conditions, step labels and the control store
// ---------------------------------------------------------------------------
package pesw_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_STREAM_ID     = 2'd0;
  localparam logic [1:0] CFG_START_CODE_ID = 2'd1;
  localparam logic [1:0] CFG_MAX_BUF_SIZE  = 2'd2;
  localparam logic [1:0] CFG_LPCM_FORMAT   = 2'd3;

  // beat kinds on in_tuser
  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  // stream id constants
  localparam logic [7:0] PRIV_STREAM_1 = 8'hbd;
  localparam logic [7:0] AUDIO_STREAM  = 8'hc0;
  localparam logic [7:0] SID_LPCM_MIN  = 8'ha0;
  localparam logic [7:0] SID_AC3_MIN   = 8'h40;
  localparam logic [5:0] MAX_STUFF     = 6'd32;

  // byte source selects
  localparam logic [4:0] SEL_ZERO    = 5'd0;
  localparam logic [4:0] SEL_ONE     = 5'd1;
  localparam logic [4:0] SEL_SCID    = 5'd2;
  localparam logic [4:0] SEL_PSZ_HI  = 5'd3;
  localparam logic [4:0] SEL_PSZ_LO  = 5'd4;
  localparam logic [4:0] SEL_H80     = 5'd5;
  localparam logic [4:0] SEL_FLAGS   = 5'd6;
  localparam logic [4:0] SEL_HLEN    = 5'd7;
  localparam logic [4:0] SEL_TS0     = 5'd8;
  localparam logic [4:0] SEL_TS1     = 5'd9;
  localparam logic [4:0] SEL_TS2     = 5'd10;
  localparam logic [4:0] SEL_TS3     = 5'd11;
  localparam logic [4:0] SEL_TS4     = 5'd12;
  localparam logic [4:0] SEL_H10     = 5'd13;
  localparam logic [4:0] SEL_BUF_HI  = 5'd14;
  localparam logic [4:0] SEL_BUF_LO  = 5'd15;
  localparam logic [4:0] SEL_HFF     = 5'd16;
  localparam logic [4:0] SEL_SID     = 5'd17;
  localparam logic [4:0] SEL_H07     = 5'd18;
  localparam logic [4:0] SEL_H04     = 5'd19;
  localparam logic [4:0] SEL_H0C     = 5'd20;
  localparam logic [4:0] SEL_LPCM    = 5'd21;
  localparam logic [4:0] SEL_FCNT    = 5'd22;
  localparam logic [4:0] SEL_TRL_HI  = 5'd23;
  localparam logic [4:0] SEL_TRL_LO  = 5'd24;

  // branch conditions
  localparam logic [3:0] C_NEVER           = 4'd0;
  localparam logic [3:0] C_ALWAYS          = 4'd1;
  localparam logic [3:0] C_NO_PTS          = 4'd2;
  localparam logic [3:0] C_NO_PTS_NO_FIRST = 4'd3;
  localparam logic [3:0] C_NO_DTS          = 4'd4;
  localparam logic [3:0] C_NO_DTS_NO_FIRST = 4'd5;
  localparam logic [3:0] C_NO_FIRST        = 4'd6;
  localparam logic [3:0] C_STUFF_LEFT      = 4'd7;
  localparam logic [3:0] C_NOT_PRIV        = 4'd8;
  localparam logic [3:0] C_SID_LT40        = 4'd9;
  localparam logic [3:0] C_SID_LTA0        = 4'd10;

  // step labels
  localparam logic [5:0] ST_START = 6'd0;
  localparam logic [5:0] ST_PSTD  = 6'd19;
  localparam logic [5:0] ST_FF    = 6'd22;
  localparam logic [5:0] ST_AC3   = 6'd30;
  localparam logic [5:0] ST_LAST  = 6'd32;
  localparam logic [5:0] PC_END   = 6'd63;

  typedef struct packed {
    logic [4:0] sel;
    logic       ts_dts;   // timestamp bytes come from dts
    logic [3:0] cond1;    // first branch, higher priority
    logic [5:0] tgt1;
    logic [3:0] cond2;
    logic [5:0] tgt2;
  } ucode_t;

  function automatic ucode_t pesw_ucode(input logic [5:0] pc);
    ucode_t w;
    w = '{SEL_ZERO, 1'b0, C_ALWAYS, PC_END, C_NEVER, PC_END};
    case (pc)
      6'd0:  w = '{SEL_ZERO,   1'b0, C_NEVER,           PC_END, C_NEVER,    PC_END};
      6'd1:  w = '{SEL_ZERO,   1'b0, C_NEVER,           PC_END, C_NEVER,    PC_END};
      6'd2:  w = '{SEL_ONE,    1'b0, C_NEVER,           PC_END, C_NEVER,    PC_END};
      6'd3:  w = '{SEL_SCID,   1'b0, C_NEVER,           PC_END, C_NEVER,    PC_END};
      6'd4:  w = '{SEL_PSZ_HI, 1'b0, C_NEVER,           PC_END, C_NEVER,    PC_END};
      6'd5:  w = '{SEL_PSZ_LO, 1'b0, C_NEVER,           PC_END, C_NEVER,    PC_END};
      6'd6:  w = '{SEL_H80,    1'b0, C_NEVER,           PC_END, C_NEVER,    PC_END};
      6'd7:  w = '{SEL_FLAGS,  1'b0, C_NEVER,           PC_END, C_NEVER,    PC_END};
      6'd8:  w = '{SEL_HLEN,   1'b0, C_NO_PTS_NO_FIRST, ST_FF,  C_NO_PTS,   ST_PSTD};
      6'd9:  w = '{SEL_TS0,    1'b0, C_NEVER,           PC_END, C_NEVER,    PC_END};
      6'd10: w = '{SEL_TS1,    1'b0, C_NEVER,           PC_END, C_NEVER,    PC_END};
      6'd11: w = '{SEL_TS2,    1'b0, C_NEVER,           PC_END, C_NEVER,    PC_END};
      6'd12: w = '{SEL_TS3,    1'b0, C_NEVER,           PC_END, C_NEVER,    PC_END};
      6'd13: w = '{SEL_TS4,    1'b0, C_NO_DTS_NO_FIRST, ST_FF,  C_NO_DTS,   ST_PSTD};
      6'd14: w = '{SEL_TS0,    1'b1, C_NEVER,           PC_END, C_NEVER,    PC_END};
      6'd15: w = '{SEL_TS1,    1'b1, C_NEVER,           PC_END, C_NEVER,    PC_END};
      6'd16: w = '{SEL_TS2,    1'b1, C_NEVER,           PC_END, C_NEVER,    PC_END};
      6'd17: w = '{SEL_TS3,    1'b1, C_NEVER,           PC_END, C_NEVER,    PC_END};
      6'd18: w = '{SEL_TS4,    1'b1, C_NO_FIRST,        ST_FF,  C_NEVER,    PC_END};
      6'd19: w = '{SEL_H10,    1'b0, C_NEVER,           PC_END, C_NEVER,    PC_END};
      6'd20: w = '{SEL_BUF_HI, 1'b0, C_NEVER,           PC_END, C_NEVER,    PC_END};
      6'd21: w = '{SEL_BUF_LO, 1'b0, C_NEVER,           PC_END, C_NEVER,    PC_END};
      6'd22: w = '{SEL_HFF,    1'b0, C_STUFF_LEFT,      ST_FF,  C_NOT_PRIV, PC_END};
      6'd23: w = '{SEL_SID,    1'b0, C_SID_LT40,        PC_END, C_SID_LTA0, ST_AC3};
      6'd24: w = '{SEL_H07,    1'b0, C_NEVER,           PC_END, C_NEVER,    PC_END};
      6'd25: w = '{SEL_ZERO,   1'b0, C_NEVER,           PC_END, C_NEVER,    PC_END};
      6'd26: w = '{SEL_H04,    1'b0, C_NEVER,           PC_END, C_NEVER,    PC_END};
      6'd27: w = '{SEL_H0C,    1'b0, C_NEVER,           PC_END, C_NEVER,    PC_END};
      6'd28: w = '{SEL_LPCM,   1'b0, C_NEVER,           PC_END, C_NEVER,    PC_END};
      6'd29: w = '{SEL_H80,    1'b0, C_ALWAYS,          PC_END, C_NEVER,    PC_END};
      6'd30: w = '{SEL_FCNT,   1'b0, C_NEVER,           PC_END, C_NEVER,    PC_END};
      6'd31: w = '{SEL_TRL_HI, 1'b0, C_NEVER,           PC_END, C_NEVER,    PC_END};
      6'd32: w = '{SEL_TRL_LO, 1'b0, C_ALWAYS,          PC_END, C_NEVER,    PC_END};
      default: w = '{SEL_ZERO, 1'b0, C_ALWAYS,          PC_END, C_NEVER,    PC_END};
    endcase
    return w;
  endfunction

endpackage

/* rtl/pes_header_writer.sv */
// ---------------------------------------------------------------------------
// pes_header_writer: mpeg-2 pes packetizer for one elementary stream
// a header beat expands into the pes header byte run, a payload beat
// passes one byte through
// ---------------------------------------------------------------------------
// A payload beat (in_tuser = 1) appears on the output register the next cycle
// with its tlast. A header beat (in_tuser = 0) is latched, then a microcoded
// sequencer walks a 33-step control store and emits one header byte per cycle
// unless the output stalls: start code, packet length, marker, flags, header
// data length, pts/dts, p-std buffer extension, 0xff plus up to 32 stuffing
// bytes, and the private stream 1 sub-header. A header of 10 to 62 bytes
// leaves through the single byte-wide output register that the sequencer
// feeds; output stalls simply hold the step counter. The next beat is taken
// once the last header byte is loaded and the output register is free.
// Configuration is written through cfg_we/cfg_addr/cfg_wdata; the user must
// do so only while the block is idle, which the block does not enforce.
// ---------------------------------------------------------------------------
module pes_header_writer
  import pesw_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  // config write port
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [19:0]  cfg_wdata,
  // input beats
  input  logic         in_tvalid,
  output logic         in_tready,
  // [0] pts_valid, [33:1] pts, [66:34] dts, [74:67] header length,
  // [90:75] packet length, [96:91] stuffing count, [112:97] trailer size,
  // [120:113] frame_count, [121] first_packet, [129:122] data_byte, zero pad
  input  logic [135:0] in_tdata,
  input  logic         in_tuser,   // [0] kind
  input  logic         in_tlast,   // data_last
  // output beats
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [7:0]   out_tdata,  // [7:0] out_byte
  output logic         out_tlast   // last
);

  // configuration registers
  logic [7:0]  stream_id_r;
  logic [7:0]  start_code_id_r;
  logic [19:0] max_buf_size_r;
  logic [7:0]  lpcm_format_r;

  // sequencer control
  logic        busy_r;
  logic [5:0]  pc_r;
  logic [5:0]  pc_nxt;
  logic [5:0]  cnt_r;         // stuffing bytes still to send

  // latched header fields
  logic [32:0] pts_r;
  logic [32:0] dts_r;
  logic        has_pts_r;
  logic        has_dts_r;
  logic        first_r;
  logic [15:0] psize_r;
  logic [7:0]  hlen_r;
  logic [15:0] trailer_r;
  logic [7:0]  fcnt_r;

  // output register
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_last_r;
  logic        out_valid_nxt;
  logic [7:0]  out_byte_nxt;
  logic        out_last_nxt;

  // input field views
  logic        f_pts_valid;
  logic [32:0] f_pts;
  logic [32:0] f_dts;
  logic [7:0]  f_hdr_len;
  logic [15:0] f_pkt_size;
  logic [5:0]  f_stuffing;
  logic [15:0] f_trailer;
  logic [7:0]  f_frame_count;
  logic        f_first;
  logic [7:0]  f_data_byte;
  logic [5:0]  stuff_sat;

  logic        out_free;
  logic        in_acc;
  logic        step_fire;
  logic        step_last;
  ucode_t      cw;
  logic        jmp1;
  logic        jmp2;
  logic [32:0] ts;
  logic [3:0]  ts_prefix;
  logic [15:0] buf_word;
  logic [7:0]  flags;
  logic [7:0]  step_byte;

  assign f_pts_valid   = in_tdata[0];
  assign f_pts         = in_tdata[33:1];
  assign f_dts         = in_tdata[66:34];
  assign f_hdr_len     = in_tdata[74:67];
  assign f_pkt_size    = in_tdata[90:75];
  assign f_stuffing    = in_tdata[96:91];
  assign f_trailer     = in_tdata[112:97];
  assign f_frame_count = in_tdata[120:113];
  assign f_first       = in_tdata[121];
  assign f_data_byte   = in_tdata[129:122];

  // stuffing saturates at 32 in both the byte count and the length byte
  assign stuff_sat = (f_stuffing > MAX_STUFF) ? MAX_STUFF : f_stuffing;

  // handshake
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !busy_r && out_free;
  assign in_acc    = in_tvalid && in_tready;
  assign step_fire = busy_r && out_free;

  // control word and branch evaluation
  assign cw = pesw_ucode(pc_r);

  function automatic logic cond_true(input logic [3:0] c, input logic has_pts,
                                     input logic has_dts, input logic first,
                                     input logic stuff_left, input logic priv,
                                     input logic [7:0] sid);
    logic r;
    case (c)
      C_NEVER:           r = 1'b0;
      C_ALWAYS:          r = 1'b1;
      C_NO_PTS:          r = !has_pts;
      C_NO_PTS_NO_FIRST: r = !has_pts && !first;
      C_NO_DTS:          r = !has_dts;
      C_NO_DTS_NO_FIRST: r = !has_dts && !first;
      C_NO_FIRST:        r = !first;
      C_STUFF_LEFT:      r = stuff_left;
      C_NOT_PRIV:        r = !priv;
      C_SID_LT40:        r = sid < SID_AC3_MIN;
      C_SID_LTA0:        r = sid < SID_LPCM_MIN;
      default:           r = 1'b0;
    endcase
    return r;
  endfunction

  assign jmp1 = cond_true(cw.cond1, has_pts_r, has_dts_r, first_r, cnt_r != 6'd0,
                          start_code_id_r == PRIV_STREAM_1, stream_id_r);
  assign jmp2 = cond_true(cw.cond2, has_pts_r, has_dts_r, first_r, cnt_r != 6'd0,
                          start_code_id_r == PRIV_STREAM_1, stream_id_r);

  always_comb begin
    if (jmp1) begin
      pc_nxt = cw.tgt1;
    end else if (jmp2) begin
      pc_nxt = cw.tgt2;
    end else begin
      pc_nxt = 6'(pc_r + 6'd1);
    end
  end

  assign step_last = (pc_nxt == PC_END);

  // datapath: timestamp in marker-bit form, buffer extension, flags
  assign ts        = cw.ts_dts ? dts_r : pts_r;
  assign ts_prefix = cw.ts_dts ? 4'h1 : (has_dts_r ? 4'h3 : 4'h2);
  // audio scales the buffer size by 128, everything else by 1024
  assign buf_word  = (stream_id_r == AUDIO_STREAM)
                   ? (16'h4000 | {3'b000, max_buf_size_r[19:7]})
                   : (16'h6000 | {6'b000000, max_buf_size_r[19:10]});
  assign flags     = {has_pts_r, has_dts_r, 5'b00000, first_r};

  always_comb begin
    case (cw.sel)
      SEL_ZERO:   step_byte = 8'h00;
      SEL_ONE:    step_byte = 8'h01;
      SEL_SCID:   step_byte = start_code_id_r;
      SEL_PSZ_HI: step_byte = psize_r[15:8];
      SEL_PSZ_LO: step_byte = psize_r[7:0];
      SEL_H80:    step_byte = 8'h80;
      SEL_FLAGS:  step_byte = flags;
      SEL_HLEN:   step_byte = hlen_r;
      SEL_TS0:    step_byte = {ts_prefix, ts[32:30], 1'b1};
      SEL_TS1:    step_byte = ts[29:22];
      SEL_TS2:    step_byte = {ts[21:15], 1'b1};
      SEL_TS3:    step_byte = ts[14:7];
      SEL_TS4:    step_byte = {ts[6:0], 1'b1};
      SEL_H10:    step_byte = 8'h10;
      SEL_BUF_HI: step_byte = buf_word[15:8];
      SEL_BUF_LO: step_byte = buf_word[7:0];
      SEL_HFF:    step_byte = 8'hff;
      SEL_SID:    step_byte = stream_id_r;
      SEL_H07:    step_byte = 8'h07;
      SEL_H04:    step_byte = 8'h04;
      SEL_H0C:    step_byte = 8'h0c;
      SEL_LPCM:   step_byte = lpcm_format_r;
      SEL_FCNT:   step_byte = fcnt_r;
      SEL_TRL_HI: step_byte = trailer_r[15:8];
      SEL_TRL_LO: step_byte = trailer_r[7:0];
      default:    step_byte = 8'h00;
    endcase
  end

  // output register: loaded by a sequencer step or by a payload beat
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (step_fire) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = step_byte;
      out_last_nxt  = step_last;
    end else if (in_acc && in_tuser == KIND_PAYLOAD) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = f_data_byte;
      out_last_nxt  = in_tlast;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r          <= 1'b0;
      pc_r            <= ST_START;
      out_valid_r     <= 1'b0;
      stream_id_r     <= 8'd192;
      start_code_id_r <= 8'd192;
      max_buf_size_r  <= 20'd4096;
      lpcm_format_r   <= 8'd1;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_acc && in_tuser == KIND_HEADER) begin
        busy_r <= 1'b1;
        pc_r   <= ST_START;
      end else if (step_fire) begin
        pc_r <= pc_nxt;
        if (step_last) begin
          busy_r <= 1'b0;
        end
      end
      if (cfg_we) begin
        case (cfg_addr)
          CFG_STREAM_ID:     stream_id_r     <= cfg_wdata[7:0];
          CFG_START_CODE_ID: start_code_id_r <= cfg_wdata[7:0];
          CFG_MAX_BUF_SIZE:  max_buf_size_r  <= cfg_wdata;
          CFG_LPCM_FORMAT:   lpcm_format_r   <= cfg_wdata[7:0];
          default:           lpcm_format_r   <= lpcm_format_r;
        endcase
      end
    end
  end

  // header fields and output payload
  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    if (in_acc && in_tuser == KIND_HEADER) begin
      pts_r     <= f_pts;
      dts_r     <= f_dts;
      has_pts_r <= f_pts_valid;
      has_dts_r <= f_pts_valid && (f_dts != f_pts);
      first_r   <= f_first;
      psize_r   <= f_pkt_size;
      hlen_r    <= 8'(f_hdr_len - 8'd3 + {2'b00, stuff_sat});
      trailer_r <= 16'(f_trailer + 16'd1);
      fcnt_r    <= f_frame_count;
      cnt_r     <= stuff_sat;
    end else if (step_fire && pc_r == ST_FF && jmp1) begin
      cnt_r <= 6'(cnt_r - 6'd1);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  // the step counter never rests outside the program while a header runs
  a_pc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (pc_r <= ST_LAST))
    else $error("sequencer step out of program");

  // the end of a header run leaves its final byte waiting, marked last
  a_end_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy_r) && $past(rst_n)) |-> (out_valid_r && out_last_r))
    else $error("header run ended without a last byte");

  // the stuffing count only moves on the 0xff step
  a_stuff_step: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && $past(busy_r) && !$stable(cnt_r)) |-> ($past(pc_r) == ST_FF))
    else $error("stuffing count changed outside the stuffing step");

  // a payload beat shows up on the output register right away
  a_payload_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser == KIND_PAYLOAD) |=> out_valid_r)
    else $error("payload beat not registered");
`endif

endmodule
